[sv/wsfu_pkg.sv]
// Shared types and constants for the WebSocket frame unmasker.
// No dependencies; used by wsfu_parser and websocket_frame_unmasker_unit.
`default_nettype none

package wsfu_pkg;

  // Opcode bytes (FIN set) recognized in the first header byte
  localparam logic [7:0] OP_TEXT  = 8'h81;
  localparam logic [7:0] OP_PING  = 8'h89;
  localparam logic [7:0] OP_CLOSE = 8'h88;

  // Length field codes in the second header byte
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Header byte counter and payload start positions
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_OPCODE  = 4'd0;
  localparam logic [POS_W-1:0] POS_LENGTH  = 4'd1;
  localparam logic [POS_W-1:0] START_BASE  = 4'd6;
  localparam logic [POS_W-1:0] START_EXT16 = 4'd8;
  localparam logic [POS_W-1:0] START_EXT64 = 4'd14;
  localparam logic [POS_W:0]   MASK_BYTES  = 5'd4;

  // Frame class
  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_PING  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_BAD   = 2'd3
  } kind_e;

  // One result item
  typedef struct packed {
    logic        end_of_frame;
    kind_e       frame_kind;
    logic        payload_valid;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

`default_nettype wire

[sv/wsfu_parser.sv]
// Frame parser: header tracking, mask capture and payload unmasking.
// Depends on wsfu_pkg. State advances only on adv_i.
`default_nettype none

module wsfu_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,        // current byte is consumed this cycle
  input  wire logic [7:0]       frame_byte_i,
  input  wire logic             message_end_i,
  output logic                  res_valid_o,  // this byte yields a result
  output wsfu_pkg::result_t     res_o
);

  logic [wsfu_pkg::POS_W-1:0] pos_q, pos_d;
  logic [wsfu_pkg::POS_W-1:0] start_q, start_d;
  logic [1:0]                 phase_q, phase_d;
  wsfu_pkg::kind_e            kind_q, kind_d;
  logic [7:0]                 mask_q [4];
  logic                       mask_we;
  logic [1:0]                 mask_slot;
  logic                       emit;
  logic [7:0]                 value;

  // Mask slot: (pos + 4 - start) mod 4
  assign mask_slot = pos_q[1:0] - start_q[1:0];

  // Per-byte decode
  always_comb begin
    pos_d   = pos_q;
    start_d = start_q;
    phase_d = phase_q;
    kind_d  = kind_q;
    mask_we = 1'b0;
    emit    = 1'b0;
    value   = 8'h00;
    if (pos_q == wsfu_pkg::POS_OPCODE) begin
      unique case (frame_byte_i)
        wsfu_pkg::OP_TEXT:  kind_d = wsfu_pkg::KIND_TEXT;
        wsfu_pkg::OP_PING:  kind_d = wsfu_pkg::KIND_PING;
        wsfu_pkg::OP_CLOSE: kind_d = wsfu_pkg::KIND_CLOSE;
        default:            kind_d = wsfu_pkg::KIND_BAD;
      endcase
      pos_d = wsfu_pkg::POS_LENGTH;
    end else if (pos_q == wsfu_pkg::POS_LENGTH) begin
      unique case (frame_byte_i[6:0])
        wsfu_pkg::LEN_EXT16: start_d = wsfu_pkg::START_EXT16;
        wsfu_pkg::LEN_EXT64: start_d = wsfu_pkg::START_EXT64;
        default:             start_d = wsfu_pkg::START_BASE;
      endcase
      pos_d = pos_q + 4'd1;
    end else if (pos_q < start_q) begin
      // extended length bytes are skipped, the last four header bytes are the mask
      mask_we = ({1'b0, pos_q} + wsfu_pkg::MASK_BYTES) >= {1'b0, start_q};
      pos_d   = pos_q + 4'd1;
    end else begin
      if (kind_q != wsfu_pkg::KIND_BAD) begin
        value = frame_byte_i ^ mask_q[phase_q];
        emit  = 1'b1;
      end
      phase_d = phase_q + 2'd1;
    end
    // message end: next byte opens a new frame
    if (message_end_i) begin
      pos_d   = wsfu_pkg::POS_OPCODE;
      start_d = wsfu_pkg::START_BASE;
      phase_d = 2'd0;
    end
  end

  assign res_valid_o          = emit | message_end_i;
  assign res_o.payload_byte   = value;
  assign res_o.payload_valid  = emit;
  assign res_o.frame_kind     = kind_d;
  assign res_o.end_of_frame   = message_end_i;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= wsfu_pkg::POS_OPCODE;
      start_q <= wsfu_pkg::START_BASE;
      phase_q <= 2'd0;
      kind_q  <= wsfu_pkg::KIND_TEXT;
    end else if (adv_i) begin
      pos_q   <= pos_d;
      start_q <= start_d;
      phase_q <= phase_d;
      kind_q  <= kind_d;
    end
  end

  // Mask key bytes
  always_ff @(posedge clk_i) begin
    if (adv_i && mask_we) begin
      mask_q[mask_slot] <= frame_byte_i;
    end
  end

endmodule

`default_nettype wire

[sv/websocket_frame_unmasker_unit.sv]
// Top level of the WebSocket frame unmasker: stream ports, input and result registers.
// Depends on wsfu_pkg and wsfu_parser.
`default_nettype none

// Takes one received frame byte per request on the slave stream, tlast on the
// last byte of the message. The first byte sets the frame class (text, ping,
// close, unsupported), the second byte selects where the 4-byte mask key sits
// (after 0, 2 or 8 extended length bytes), and every byte after the mask key is unmasked and
// sent out with tuser[0] set. The declared length and the mask bit are ignored;
// the frame ends at tlast. The byte carrying tlast always yields a request with
// tlast set; unsupported frames yield only that one. Throughput is one byte per
// clock while the result side keeps draining: the byte is held in the input
// register, decoded against the held header state, and the result is registered.
// Header bytes that are not the last of a message yield nothing.
module websocket_frame_unmasker_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  wire logic        s_axis_tlast,   // message_end
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] payload_byte
  output logic [2:0]       m_axis_tuser,   // [0] payload_valid, [2:1] frame_kind
  output logic             m_axis_tlast    // end_of_frame
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              adv;
  logic              res_valid;
  wsfu_pkg::result_t res;
  logic              out_valid_q;
  wsfu_pkg::result_t out_q;

  // Move the held byte into the result stage when that stage is free or draining
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  wsfu_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .frame_byte_i  (in_byte_q),
    .message_end_i (in_last_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.payload_byte;
  assign m_axis_tuser  = {out_q.frame_kind, out_q.payload_valid};
  assign m_axis_tlast  = out_q.end_of_frame;

`ifndef SYNTH
  // A request without a payload byte only ever closes a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("non-payload request without tlast");

  // Unsupported frames never deliver payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] != wsfu_pkg::KIND_BAD)
    else $error("payload delivered for unsupported frame");

  // The payload byte is zero when no payload is carried
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
    else $error("nonzero data on non-payload request");

  // A held byte that cannot advance keeps the input side stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while both stages are full");
`endif

endmodule

`default_nettype wire

[tb/sv/websocket_frame_unmasker_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for websocket_frame_unmasker_unit: directed and random frames, scoreboard check.
// Depends on wsfu_pkg and the unit's RTL.

module websocket_frame_unmasker_unit_tb;

  localparam int unsigned ITEM_TARGET   = 1100;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned IDLE_PERCENT  = 7;
  localparam int unsigned HOLD_AFTER    = 150;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 20;

  // Tracks the frame state and holds the results still owed by the unit
  class unmask_scoreboard;
    logic [wsfu_pkg::POS_W-1:0] byte_pos;
    logic [wsfu_pkg::POS_W-1:0] payload_start;
    logic [7:0]                 mask_key [4];
    logic [1:0]                 mask_phase;
    wsfu_pkg::kind_e            frame_class;
    wsfu_pkg::result_t          owed_q [$];
    int unsigned                errors;
    int unsigned                results_seen;

    function new();
      byte_pos      = wsfu_pkg::POS_OPCODE;
      payload_start = wsfu_pkg::START_BASE;
      mask_phase    = '0;
      frame_class   = wsfu_pkg::KIND_TEXT;
      foreach (mask_key[i]) mask_key[i] = '0;
      errors        = 0;
      results_seen  = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Advance the frame state by one accepted byte and queue its result, if any
    function void note_request(input logic [7:0] b, input logic last);
      wsfu_pkg::result_t r;
      logic    emit;
      logic [1:0] slot;
      r    = '0;
      emit = 1'b0;
      if (byte_pos == wsfu_pkg::POS_OPCODE) begin
        case (b)
          wsfu_pkg::OP_TEXT:  frame_class = wsfu_pkg::KIND_TEXT;
          wsfu_pkg::OP_PING:  frame_class = wsfu_pkg::KIND_PING;
          wsfu_pkg::OP_CLOSE: frame_class = wsfu_pkg::KIND_CLOSE;
          default:            frame_class = wsfu_pkg::KIND_BAD;
        endcase
        byte_pos = wsfu_pkg::POS_LENGTH;
      end else if (byte_pos == wsfu_pkg::POS_LENGTH) begin
        // mask bit is ignored, only the 7-bit length code counts
        case (b[6:0])
          wsfu_pkg::LEN_EXT16: payload_start = wsfu_pkg::START_EXT16;
          wsfu_pkg::LEN_EXT64: payload_start = wsfu_pkg::START_EXT64;
          default:             payload_start = wsfu_pkg::START_BASE;
        endcase
        byte_pos = wsfu_pkg::POS_LENGTH + 1'b1;
      end else if (byte_pos < payload_start) begin
        // the four bytes just before the payload form the mask key
        if ({1'b0, byte_pos} + wsfu_pkg::MASK_BYTES >= {1'b0, payload_start}) begin
          slot = 2'(byte_pos - payload_start);
          mask_key[slot] = b;
        end
        byte_pos = byte_pos + 1'b1;
      end else begin
        if (frame_class != wsfu_pkg::KIND_BAD) begin
          r.payload_byte = b ^ mask_key[mask_phase];
          emit = 1'b1;
        end
        mask_phase = mask_phase + 1'b1;
      end

      if (emit || last) begin
        r.payload_valid = emit;
        r.frame_kind    = frame_class;
        r.end_of_frame  = last;
        owed_q = {owed_q, r};
      end

      if (last) begin
        byte_pos      = wsfu_pkg::POS_OPCODE;
        payload_start = wsfu_pkg::START_BASE;
        mask_phase    = '0;
      end
    endfunction

    // Compare one accepted result with the oldest owed one
    task check_result(input logic [7:0] data, input logic [2:0] user, input logic last);
      wsfu_pkg::result_t exp_r;
      results_seen++;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result data=%02h user=%03b last=%0b", data, user, last));
      end else begin
        exp_r = owed_q.pop_front();
        if (data !== exp_r.payload_byte)
          report($sformatf("payload_byte %02h, want %02h", data, exp_r.payload_byte));
        if (user[0] !== exp_r.payload_valid)
          report($sformatf("payload_valid %0b, want %0b", user[0], exp_r.payload_valid));
        if (user[2:1] !== exp_r.frame_kind)
          report($sformatf("frame_kind %0d, want %0d", user[2:1], exp_r.frame_kind));
        if (last !== exp_r.end_of_frame)
          report($sformatf("end_of_frame %0b, want %0b", last, exp_r.end_of_frame));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  unmask_scoreboard sb = new();
  logic [7:0]  frame_bytes [$];
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;

  websocket_frame_unmasker_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(b, last);
    items_sent++;
  endtask

  task automatic send_message();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Header, extended length, mask key and random payload
  task automatic build_frame(input logic [7:0] opcode, input logic [7:0] len_byte,
                             input int unsigned payload_len);
    int unsigned ext_len;
    ext_len = (len_byte[6:0] == wsfu_pkg::LEN_EXT16) ? 2 :
              (len_byte[6:0] == wsfu_pkg::LEN_EXT64) ? 8 : 0;
    frame_bytes.delete();
    frame_bytes = {opcode, len_byte};
    repeat (ext_len + wsfu_pkg::MASK_BYTES + payload_len)
      frame_bytes = {frame_bytes, 8'($urandom_range(255))};
  endtask

  // Stop offering and wait until every owed result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls plus one long hold-off while input keeps coming
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (!held && sb.results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Stimulus
  initial begin : byte_source
    int unsigned frame_no;
    int unsigned pick;
    logic [7:0]  opcode;
    logic [7:0]  len_byte;
    int unsigned payload_len;
    frame_no = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // text, 16-bit extended length with mask bit set, all-zero and all-one bytes
    frame_bytes = '{wsfu_pkg::OP_TEXT, 8'hFE, 8'h00, 8'h05, 8'hFF, 8'h00, 8'hA5, 8'h5A,
                    8'h00, 8'hFF};
    send_message();
    // ping cut off on the length byte
    frame_bytes = '{wsfu_pkg::OP_PING, 8'h7F};
    send_message();
    // close cut off on the opcode byte
    frame_bytes = '{wsfu_pkg::OP_CLOSE};
    send_message();
    // pong opcode is unsupported here: only the end result comes out
    frame_bytes = '{8'h8A, 8'h82, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
    send_message();
    // unknown opcode, mask bit set with zero length
    frame_bytes = '{8'hFF, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04, 8'h10};
    send_message();

    // Random frames, mostly well formed, some cut short
    while (items_sent < ITEM_TARGET) begin
      steady = (frame_no >= 15 && frame_no < 30);
      if (frame_no == 40) wait_drained();

      pick = $urandom_range(99);
      if (pick < 30)      opcode = wsfu_pkg::OP_TEXT;
      else if (pick < 50) opcode = wsfu_pkg::OP_PING;
      else if (pick < 65) opcode = wsfu_pkg::OP_CLOSE;
      else if (pick < 75) opcode = 8'h8A;
      else                opcode = 8'($urandom_range(255));

      pick = $urandom_range(9);
      if (pick < 2)       len_byte = {1'($urandom_range(1)), wsfu_pkg::LEN_EXT16};
      else if (pick < 4)  len_byte = {1'($urandom_range(1)), wsfu_pkg::LEN_EXT64};
      else                len_byte = 8'($urandom_range(255));

      payload_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
      build_frame(opcode, len_byte, payload_len);
      if ($urandom_range(9) == 0)
        frame_bytes = frame_bytes[0:$urandom_range(frame_bytes.size() - 1)];
      send_message();
      frame_no++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
